/* rtl/core/arpc_pkg.sv */
// arpc_pkg: shared constants, codes and types of the arp responder with cache
// no dependencies; imported by arpc_cell and arp_responder_with_cache_unit
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int CACHE_ENTRIES = 8;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    localparam logic [10:0] MIN_FRAME  = 11'd42;
    localparam logic [15:0] HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  HLEN_MAC   = 8'd6;
    localparam logic [7:0]  PLEN_IP    = 8'd4;
    localparam logic [15:0] OP_REQUEST = 16'h0001;

    localparam logic OPC_PACKET = 1'b0;
    localparam logic OPC_QUERY  = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_WB
    } state_t;

    // passed from cell to cell: lowest match so far and its mac
    typedef struct packed {
        logic        found;
        logic [47:0] mac;
    } link_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic        cmp;
        logic        store;
        logic        full;
        logic        any_found;
        cnt_t        count;
        logic [31:0] key_ip;
        logic [47:0] mac;
    } ctl_t;

endpackage

/* rtl/core/arpc_cell.sv */
// arpc_cell: one cache entry with its compare and its link in the priority chain
// depends on arpc_pkg
`timescale 1ns / 1ps

module arpc_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  arpc_pkg::idx_t cell_idx,
    input  arpc_pkg::ctl_t ctl,
    input  arpc_pkg::link_t chain_in,
    output arpc_pkg::link_t chain_out
);
    import arpc_pkg::*;

    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic        match_reg;
    logic        match_next;
    logic        first;
    logic        write_en;
    cnt_t        my_idx;

    assign my_idx = CNT_W'(cell_idx);

    // entries at or above the fill count are never considered
    always_comb
    begin
        match_next = match_reg;
        if (ctl.cmp)
        begin
            match_next = (ip_reg == ctl.key_ip) && (my_idx < ctl.count);
        end
    end

    assign first = match_reg & ~chain_in.found;

    assign chain_out.found = chain_in.found | match_reg;
    assign chain_out.mac   = first ? mac_reg : chain_in.mac;

    // update the first match, else append at the fill count, else replace entry 0
    assign write_en = ctl.store &
                      (first | (~ctl.any_found &
                                ((ctl.full & (my_idx == '0)) |
                                 (~ctl.full & (my_idx == ctl.count)))));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            ip_reg  <= ctl.key_ip;
            mac_reg <= ctl.mac;
        end
    end

endmodule

/* rtl/core/arp_responder_with_cache_unit.sv */
// arp_responder_with_cache_unit: top level, item control, config and result registers
// depends on arpc_pkg and arpc_cell
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// item      in         start & !busy          opcode .. query_ip
// result    out        done, one cycle        packet_accepted .. request_ip
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// each item goes from accept to result through a compare of the key in every
// cell, a resolve of the lowest match along the cell chain with write back, and
// the result register; busy is high during the compare and the write back.
// reset clears the fill count, so the cache is empty at once, no clearing pass.
// done is one cycle wide, results last to the next item; the receiver cannot stall.

module arp_responder_with_cache_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [10:0] frame_len,
    input  logic [15:0] hw_type,
    input  logic [15:0] proto_type,
    input  logic [7:0]  hw_addr_len,
    input  logic [7:0]  proto_addr_len,
    input  logic [15:0] arp_operation,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [31:0] target_ip,
    input  logic [31:0] query_ip,
    output logic        done,
    output logic        packet_accepted,
    output logic        send_reply,
    output logic [47:0] reply_dest_mac,
    output logic [31:0] reply_dest_ip,
    output logic        hit,
    output logic [47:0] resolved_mac,
    output logic        send_request,
    output logic [31:0] request_ip,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0] cfg_data
);
    import arpc_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] local_ip_reg;
    cnt_t        count_reg, count_next;

    logic        opcode_reg;
    logic        pkt_ok_reg;
    logic        is_req_reg;
    logic [31:0] key_reg;
    logic [47:0] mac_reg;

    logic        accept;
    logic        pkt_ok;
    logic        wb;
    ctl_t        ctl;
    link_t       link [CACHE_ENTRIES+1];

    logic        done_next;
    logic        packet_accepted_next;
    logic        send_reply_next;
    logic [47:0] reply_dest_mac_next;
    logic [31:0] reply_dest_ip_next;
    logic        hit_next;
    logic [47:0] resolved_mac_next;
    logic        send_request_next;
    logic [31:0] request_ip_next;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start & ~busy;
    assign cfg_ready = 1'b1;
    assign wb        = (state_reg == ST_WB);

    assign pkt_ok = (frame_len >= MIN_FRAME) && (hw_type == HTYPE_ETH) &&
                    (proto_type == PTYPE_IPV4) && (hw_addr_len == HLEN_MAC) &&
                    (proto_addr_len == PLEN_IP);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_WB;
            ST_WB:   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item capture; the search key is the sender ip or the query ip
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg <= opcode;
            pkt_ok_reg <= pkt_ok;
            is_req_reg <= (arp_operation == OP_REQUEST) && (target_ip == local_ip_reg);
            key_reg    <= (opcode == OPC_QUERY) ? query_ip : sender_ip;
            mac_reg    <= sender_mac;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= 32'h0A00_020F;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOCAL_IP:  local_ip_reg <= cfg_data[31:0];
                // sender hardware address of the reply is the frame builder's
                CFG_LOCAL_MAC: ;
                default:       ;
            endcase
        end
    end

    assign ctl.cmp       = (state_reg == ST_CMP);
    assign ctl.store     = wb & (opcode_reg == OPC_PACKET) & pkt_ok_reg;
    assign ctl.full      = (count_reg == CNT_W'(CACHE_ENTRIES));
    assign ctl.any_found = link[CACHE_ENTRIES].found;
    assign ctl.count     = count_reg;
    assign ctl.key_ip    = key_reg;
    assign ctl.mac       = mac_reg;

    assign link[0] = '0;

    for (genvar g = 0; g < CACHE_ENTRIES; g++)
    begin : g_cell
        arpc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IDX_W'(g)),
            .ctl       (ctl),
            .chain_in  (link[g]),
            .chain_out (link[g+1])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.store && !ctl.any_found && !ctl.full)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        done_next            = wb;
        packet_accepted_next = 1'b0;
        send_reply_next      = 1'b0;
        reply_dest_mac_next  = '0;
        reply_dest_ip_next   = '0;
        hit_next             = 1'b0;
        resolved_mac_next    = '0;
        send_request_next    = 1'b0;
        request_ip_next      = '0;
        if (opcode_reg == OPC_PACKET)
        begin
            if (pkt_ok_reg)
            begin
                packet_accepted_next = 1'b1;
                if (is_req_reg)
                begin
                    send_reply_next     = 1'b1;
                    reply_dest_mac_next = mac_reg;
                    reply_dest_ip_next  = key_reg;
                end
            end
        end
        else if (link[CACHE_ENTRIES].found)
        begin
            hit_next          = 1'b1;
            resolved_mac_next = link[CACHE_ENTRIES].mac;
        end
        else
        begin
            send_request_next = 1'b1;
            request_ip_next   = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb)
        begin
            packet_accepted <= packet_accepted_next;
            send_reply      <= send_reply_next;
            reply_dest_mac  <= reply_dest_mac_next;
            reply_dest_ip   <= reply_dest_ip_next;
            hit             <= hit_next;
            resolved_mac    <= resolved_mac_next;
            send_request    <= send_request_next;
            request_ip      <= request_ip_next;
        end
    end

endmodule
